FILE: sv/yaz0_stream_decoder_core_defines.svh
// Assertion helpers used by the decoder control module.
`ifndef YAZ0_STREAM_DECODER_CORE_DEFINES_SVH
`define YAZ0_STREAM_DECODER_CORE_DEFINES_SVH

// same-cycle implication, checked on clk, off while rst_n is low
`define YAZ0_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define YAZ0_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: sv/yaz0_pkg.sv
package yaz0_pkg;

  localparam int WIN_AW    = 12;
  localparam int LEN_W     = 27;
  localparam int LANES     = 8;
  localparam int LANE_AW   = 3;
  localparam int CNT_W     = 4;
  localparam int HDR_BYTES = 16;

  localparam logic [8:0] LONG_BIAS  = 9'h012;
  localparam logic [8:0] SHORT_BIAS = 9'd2;

  localparam logic [2:0] PH_HEADER = 3'd0;
  localparam logic [2:0] PH_CODE   = 3'd1;
  localparam logic [2:0] PH_LIT    = 3'd2;
  localparam logic [2:0] PH_PAIR1  = 3'd3;
  localparam logic [2:0] PH_PAIR2  = 3'd4;
  localparam logic [2:0] PH_EXT    = 3'd5;

  localparam logic [1:0] FLT_OK      = 2'd0;
  localparam logic [1:0] FLT_TRUNC   = 2'd1;
  localparam logic [1:0] FLT_EARLY   = 2'd2;
  localparam logic [1:0] FLT_OVERRUN = 2'd3;

  typedef struct packed {
    logic [LANES-1:0][7:0] lanes;
    logic [CNT_W-1:0]      cnt;
    logic                  run_end;
    logic                  done;
    logic [1:0]            fault;
  } beat_t;

endpackage

FILE: sv/yaz0_hist_ram.sv
module yaz0_hist_ram
  import yaz0_pkg::*;
(
  input  logic              clk,
  input  logic              we,
  input  logic [WIN_AW-1:0] waddr,
  input  logic [7:0]        wdata,
  input  logic [WIN_AW-1:0] raddr,
  output logic [7:0]        rdata
);

  logic [7:0] mem [2**WIN_AW];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: sv/yaz0_ctrl.sv
`include "yaz0_stream_decoder_core_defines.svh"

module yaz0_ctrl
  import yaz0_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic              in_start,
  input  logic [7:0]        in_byte,
  input  logic              in_last,
  input  logic              cfg_wr_en,
  input  logic [LEN_W-1:0]  cfg_wr_data,
  output logic              mem_we,
  output logic [WIN_AW-1:0] mem_waddr,
  output logic [7:0]        mem_wdata,
  output logic [WIN_AW-1:0] mem_raddr,
  input  logic [7:0]        mem_rdata,
  output logic              beat_valid,
  output beat_t             beat,
  input  logic              beat_ack
);

  typedef enum logic [6:0] {
    S_IDLE   = 7'b0000001,
    S_DECODE = 7'b0000010,
    S_SETUP  = 7'b0000100,
    S_RD     = 7'b0001000,
    S_WR     = 7'b0010000,
    S_EMIT   = 7'b0100000,
    S_FIN    = 7'b1000000
  } st_t;

  st_t                   st_r, st_nxt;
  logic [LEN_W-1:0]      out_len_r, out_len_nxt;
  logic [WIN_AW-1:0]     ptr_r, ptr_nxt;
  logic [LEN_W-1:0]      produced_r, produced_nxt;
  logic [7:0]            code_r, code_nxt;
  logic [3:0]            bl_r, bl_nxt;
  logic [2:0]            phase_r, phase_nxt;
  logic [4:0]            hs_r, hs_nxt;
  logic [7:0]            pf_r, pf_nxt;
  logic [7:0]            ps_r, ps_nxt;
  logic                  halted_r, halted_nxt;
  logic [LANES-1:0][7:0] lanes_r, lanes_nxt;
  logic [CNT_W-1:0]      cnt_r, cnt_nxt;
  logic [1:0]            cfault_r, cfault_nxt;
  logic [7:0]            byte_r, byte_nxt;
  logic                  last_r, last_nxt;
  logic [8:0]            len_r, len_nxt;
  logic [8:0]            left_r, left_nxt;

  logic [12:0]      ref_dist;
  logic [LEN_W-1:0] remaining;
  logic [7:0]       tok_code;
  logic [3:0]       tok_bl;
  logic [2:0]       tok_phase;
  logic             fin_halt, fin_done;
  logic [1:0]       fin_fault;

  assign ref_dist  = {1'b0, pf_r[3:0], ps_r} + 13'd1;
  assign remaining = (produced_r < out_len_r) ? out_len_r - produced_r : '0;

  // advance to the next code bit
  always_comb begin
    tok_code = {code_r[6:0], 1'b0};
    tok_bl   = (bl_r != 4'd0) ? bl_r - 4'd1 : 4'd0;
    if (tok_bl == 4'd0) begin
      tok_phase = PH_CODE;
    end else begin
      tok_phase = tok_code[7] ? PH_LIT : PH_PAIR1;
    end
  end

  always_comb begin
    fin_halt  = 1'b0;
    fin_done  = 1'b0;
    fin_fault = FLT_OK;
    if (cfault_r == FLT_EARLY) begin
      fin_halt  = 1'b1;
      fin_fault = FLT_EARLY;
    end else if (cfault_r == FLT_OVERRUN) begin
      fin_halt  = 1'b1;
      fin_done  = 1'b1;
      fin_fault = FLT_OVERRUN;
    end else if (phase_r != PH_HEADER && produced_r >= out_len_r) begin
      fin_halt = 1'b1;
      fin_done = 1'b1;
    end else if (last_r) begin
      fin_halt  = 1'b1;
      fin_fault = FLT_TRUNC;
    end
  end

  assign in_ready = (st_r == S_IDLE);

  always_comb begin
    st_nxt       = st_r;
    out_len_nxt  = cfg_wr_en ? cfg_wr_data : out_len_r;
    ptr_nxt      = ptr_r;
    produced_nxt = produced_r;
    code_nxt     = code_r;
    bl_nxt       = bl_r;
    phase_nxt    = phase_r;
    hs_nxt       = hs_r;
    pf_nxt       = pf_r;
    ps_nxt       = ps_r;
    halted_nxt   = halted_r;
    lanes_nxt    = lanes_r;
    cnt_nxt      = cnt_r;
    cfault_nxt   = cfault_r;
    byte_nxt     = byte_r;
    last_nxt     = last_r;
    len_nxt      = len_r;
    left_nxt     = left_r;
    mem_we       = 1'b0;
    mem_waddr    = ptr_r;
    mem_wdata    = byte_r;
    mem_raddr    = ptr_r - ref_dist[WIN_AW-1:0];
    beat_valid   = 1'b0;
    beat.lanes   = lanes_r;
    beat.cnt     = cnt_r;
    beat.run_end = 1'b0;
    beat.done    = 1'b0;
    beat.fault   = FLT_OK;

    unique case (st_r)
      S_IDLE: begin
        if (in_valid) begin
          byte_nxt = in_byte;
          last_nxt = in_last;
          if (in_start) begin
            ptr_nxt      = '0;
            produced_nxt = '0;
            code_nxt     = '0;
            bl_nxt       = '0;
            phase_nxt    = PH_HEADER;
            hs_nxt       = '0;
            pf_nxt       = '0;
            ps_nxt       = '0;
            halted_nxt   = 1'b0;
          end
          st_nxt = S_DECODE;
        end
      end
      S_DECODE: begin
        cfault_nxt = FLT_OK;
        st_nxt     = S_FIN;
        if (halted_r) begin
          st_nxt = S_IDLE;
        end else begin
          case (phase_r)
            PH_HEADER: begin
              hs_nxt = hs_r + 5'd1;
              if (hs_nxt >= 5'(HDR_BYTES)) begin
                phase_nxt = PH_CODE;
              end
            end
            PH_CODE: begin
              code_nxt  = byte_r;
              bl_nxt    = 4'd8;
              phase_nxt = byte_r[7] ? PH_LIT : PH_PAIR1;
            end
            PH_LIT: begin
              mem_we       = 1'b1;
              ptr_nxt      = ptr_r + 1'b1;
              produced_nxt = produced_r + 1'b1;
              lanes_nxt[0] = byte_r;
              cnt_nxt      = CNT_W'(1);
              code_nxt     = tok_code;
              bl_nxt       = tok_bl;
              phase_nxt    = tok_phase;
            end
            PH_PAIR1: begin
              pf_nxt    = byte_r;
              phase_nxt = PH_PAIR2;
            end
            PH_PAIR2: begin
              ps_nxt = byte_r;
              if (pf_r[7:4] == 4'd0) begin
                phase_nxt = PH_EXT;
              end else begin
                len_nxt = {5'd0, pf_r[7:4]} + SHORT_BIAS;
                st_nxt  = S_SETUP;
              end
            end
            default: begin
              len_nxt = {1'b0, byte_r} + LONG_BIAS;
              st_nxt  = S_SETUP;
            end
          endcase
        end
      end
      S_SETUP: begin
        st_nxt = S_FIN;
        if ({14'd0, ref_dist} > produced_r) begin
          cfault_nxt = FLT_EARLY;
        end else begin
          // clip the copy to what is still expected
          if ({18'd0, len_r} > remaining) begin
            left_nxt   = remaining[8:0];
            cfault_nxt = FLT_OVERRUN;
          end else begin
            left_nxt = len_r;
          end
          code_nxt  = tok_code;
          bl_nxt    = tok_bl;
          phase_nxt = tok_phase;
          if (left_nxt != 9'd0) begin
            st_nxt = S_RD;
          end
        end
      end
      S_RD: begin
        st_nxt = S_WR;
      end
      S_WR: begin
        mem_we                  = 1'b1;
        mem_wdata               = mem_rdata;
        ptr_nxt                 = ptr_r + 1'b1;
        produced_nxt            = produced_r + 1'b1;
        lanes_nxt[cnt_r[LANE_AW-1:0]] = mem_rdata;
        cnt_nxt                 = cnt_r + 1'b1;
        left_nxt                = left_r - 9'd1;
        if (left_r == 9'd1) begin
          st_nxt = S_FIN;
        end else if (cnt_nxt == CNT_W'(LANES)) begin
          st_nxt = S_EMIT;
        end else begin
          st_nxt = S_RD;
        end
      end
      S_EMIT: begin
        beat_valid = 1'b1;
        if (beat_ack) begin
          lanes_nxt = '0;
          cnt_nxt   = '0;
          st_nxt    = S_RD;
        end
      end
      S_FIN: begin
        beat.run_end = 1'b1;
        beat.done    = fin_done;
        beat.fault   = fin_fault;
        if (fin_halt || cnt_r != '0) begin
          beat_valid = 1'b1;
          if (beat_ack) begin
            halted_nxt = fin_halt;
            lanes_nxt  = '0;
            cnt_nxt    = '0;
            st_nxt     = S_IDLE;
          end
        end else begin
          st_nxt = S_IDLE;
        end
      end
      default: st_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r       <= S_IDLE;
      out_len_r  <= '0;
      ptr_r      <= '0;
      produced_r <= '0;
      code_r     <= '0;
      bl_r       <= '0;
      phase_r    <= PH_HEADER;
      hs_r       <= '0;
      pf_r       <= '0;
      ps_r       <= '0;
      halted_r   <= 1'b0;
      lanes_r    <= '0;
      cnt_r      <= '0;
      cfault_r   <= FLT_OK;
    end else begin
      st_r       <= st_nxt;
      out_len_r  <= out_len_nxt;
      ptr_r      <= ptr_nxt;
      produced_r <= produced_nxt;
      code_r     <= code_nxt;
      bl_r       <= bl_nxt;
      phase_r    <= phase_nxt;
      hs_r       <= hs_nxt;
      pf_r       <= pf_nxt;
      ps_r       <= ps_nxt;
      halted_r   <= halted_nxt;
      lanes_r    <= lanes_nxt;
      cnt_r      <= cnt_nxt;
      cfault_r   <= cfault_nxt;
    end
  end

  always_ff @(posedge clk) begin
    byte_r <= byte_nxt;
    last_r <= last_nxt;
    len_r  <= len_nxt;
    left_r <= left_nxt;
  end

  `YAZ0_ASSERT_NOW(a_cnt_max, 1'b1, cnt_r <= CNT_W'(LANES), "beat count above lane count")
  `YAZ0_ASSERT_NOW(a_rd_left, st_r == S_RD, left_r != 9'd0, "copy read with nothing left")
  `YAZ0_ASSERT_NOW(a_emit_full, st_r == S_EMIT, cnt_r == CNT_W'(LANES), "partial mid-run beat")
  `YAZ0_ASSERT_NEXT(a_wr_ptr, st_r == S_WR, ptr_r == $past(ptr_r) + 1'b1, "history ptr skipped")

endmodule

FILE: sv/yaz0_stream_decoder_core.sv
// Yaz0 decompressor: one compressed byte per request on in_*, decompressed
// bytes out in beats of up to eight on out_*. Header, code, pair and literal
// bytes pass S_IDLE, S_DECODE, S_FIN; a literal's beat leaves in S_FIN. A
// back-reference adds S_SETUP, then S_RD and S_WR per copied byte (up to 273)
// and S_EMIT per full mid-run beat before S_FIN: the 4096x8 history memory
// is read and then written for every byte. Any beat that finds the result
// register still full waits for out_tready. The result register lets the
// next request in while a beat waits on out_tready. The history needs no
// clearing pass; references before the start of output are flagged.
module yaz0_stream_decoder_core
  import yaz0_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_tvalid,
  output logic             in_tready,
  input  logic [7:0]       in_tdata,   // [7:0] in_byte
  input  logic             in_tuser,   // [0] stream_start
  input  logic             in_tlast,
  output logic             out_tvalid,
  input  logic             out_tready,
  output logic [71:0]      out_tdata,  // lane_0..lane_7 [63:0], byte_count [67:64], zero pad
  output logic [2:0]       out_tuser,  // [0] stream_done, [2:1] fault
  output logic             out_tlast,
  input  logic             cfg_wr_en,
  input  logic [LEN_W-1:0] cfg_wr_data
);

  logic              mem_we;
  logic [WIN_AW-1:0] mem_waddr, mem_raddr;
  logic [7:0]        mem_wdata, mem_rdata;
  logic              beat_valid, beat_ack;
  beat_t             beat;
  beat_t             out_r, out_nxt;
  logic              out_valid_r, out_valid_nxt;

  yaz0_hist_ram u_ram (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  yaz0_ctrl u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_tvalid),
    .in_ready    (in_tready),
    .in_start    (in_tuser),
    .in_byte     (in_tdata),
    .in_last     (in_tlast),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .mem_we      (mem_we),
    .mem_waddr   (mem_waddr),
    .mem_wdata   (mem_wdata),
    .mem_raddr   (mem_raddr),
    .mem_rdata   (mem_rdata),
    .beat_valid  (beat_valid),
    .beat        (beat),
    .beat_ack    (beat_ack)
  );

  assign beat_ack = beat_valid && (!out_valid_r || out_tready);

  always_comb begin
    out_nxt       = out_r;
    out_valid_nxt = out_valid_r;
    if (beat_ack) begin
      out_nxt       = beat;
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_r <= out_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {4'd0, out_r.cnt, out_r.lanes};
  assign out_tuser  = {out_r.fault, out_r.done};
  assign out_tlast  = out_r.run_end;

endmodule

FILE: verif/yaz0_stream_decoder_core_tb.sv
`timescale 1ns / 100ps

module yaz0_stream_decoder_core_tb;
  import yaz0_pkg::*;

  localparam int STALL_LIMIT = 20000;

  typedef struct {
    logic [LANES-1:0][7:0] lanes;
    logic [CNT_W-1:0]      cnt;
    logic                  run_end;
    logic                  done;
    logic [1:0]            fault;
  } beat_s;

  typedef struct {
    logic       start;
    logic [7:0] data;
    logic       last;
  } req_s;

  // directed row: request plus an optional typed-in expected tail
  typedef struct {
    logic       start;
    logic [7:0] data;
    logic       last;
    logic       has_exp;
    logic       exp_done;
    logic [1:0] exp_fault;
  } row_s;

  logic clk;
  logic rst_n;
  logic in_tvalid;
  logic in_tready;
  logic [7:0] in_tdata;
  logic in_tuser;
  logic in_tlast;
  logic out_tvalid;
  logic out_tready;
  logic [71:0] out_tdata;
  logic [2:0] out_tuser;
  logic out_tlast;
  logic cfg_wr_en;
  logic [LEN_W-1:0] cfg_wr_data;

  yaz0_stream_decoder_core DUT (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .in_tuser(in_tuser), .in_tlast(in_tlast),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tuser(out_tuser), .out_tlast(out_tlast),
    .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // predictor state
  logic [7:0]       hist_mem [0:4095];
  logic [11:0]      hist_wp;
  logic [LEN_W-1:0] out_len;
  logic [LEN_W-1:0] made;
  logic [7:0]       codes;
  logic [3:0]       codes_left;
  logic [2:0]       ph;
  logic [4:0]       hdr_cnt;
  logic [7:0]       ref_hi;
  logic [7:0]       ref_lo;
  logic             stopped;
  logic [7:0]       run_bytes [$];

  beat_s beat_q [$];
  int    errors;
  int    beats_seen;
  int    reqs_sent;
  int    faults_seen [4];
  logic  no_idle;
  logic  hold_out;
  int    quiet;

  function automatic void pred_reset();
    hist_wp = '0; made = '0; codes = '0; codes_left = '0; ph = PH_HEADER;
    hdr_cnt = '0; ref_hi = '0; ref_lo = '0; stopped = 1'b0;
  endfunction

  function automatic void emit_byte(logic [7:0] b);
    hist_mem[hist_wp] = b;
    hist_wp = hist_wp + 12'd1;
    made = made + 1'b1;
    run_bytes.push_back(b);
  endfunction

  function automatic void advance_token();
    codes = {codes[6:0], 1'b0};
    if (codes_left != 0) codes_left = codes_left - 4'd1;
    if (codes_left == 0) ph = PH_CODE;
    else ph = codes[7] ? PH_LIT : PH_PAIR1;
  endfunction

  function automatic logic [1:0] copy_back(int unsigned len);
    int unsigned back_dist, left, n;
    back_dist = {ref_hi[3:0], ref_lo} + 1;
    if (back_dist > made) return FLT_EARLY;
    left = (made < out_len) ? out_len - made : 0;
    n = (len > left) ? left : len;
    for (int unsigned i = 0; i < n; i++)
      emit_byte(hist_mem[hist_wp - 12'(back_dist)]);
    advance_token();
    return (len > left) ? FLT_OVERRUN : FLT_OK;
  endfunction

  // computes the beats caused by one request and queues them
  function automatic int predict_beats(req_s r);
    logic       fin;
    logic [1:0] flt;
    int         nb, cnt;
    beat_s      bt;
    fin = 1'b0; flt = FLT_OK;
    if (r.start) pred_reset();
    if (stopped) return 0;
    run_bytes.delete();
    if (ph == PH_HEADER && hdr_cnt >= HDR_BYTES) ph = PH_CODE;
    case (ph)
      PH_HEADER: begin
        hdr_cnt = hdr_cnt + 5'd1;
        if (hdr_cnt >= HDR_BYTES) ph = PH_CODE;
      end
      PH_CODE: begin
        codes = r.data; codes_left = 4'd8;
        ph = codes[7] ? PH_LIT : PH_PAIR1;
      end
      PH_LIT: begin
        emit_byte(r.data);
        advance_token();
      end
      PH_PAIR1: begin
        ref_hi = r.data; ph = PH_PAIR2;
      end
      PH_PAIR2: begin
        ref_lo = r.data;
        if (ref_hi[7:4] == 0) ph = PH_EXT;
        else flt = copy_back(ref_hi[7:4] + 2);
      end
      default: flt = copy_back(r.data + 18);
    endcase
    if (flt == FLT_EARLY) stopped = 1'b1;
    else if (flt == FLT_OVERRUN) begin
      fin = 1'b1; stopped = 1'b1;
    end else if (ph != PH_HEADER && made >= out_len) begin
      fin = 1'b1; stopped = 1'b1;
    end else if (r.last) begin
      flt = FLT_TRUNC; stopped = 1'b1;
    end
    nb = (run_bytes.size() + LANES - 1) / LANES;
    if (nb == 0 && (fin || flt != FLT_OK)) nb = 1;
    for (int k = 0; k < nb; k++) begin
      cnt = run_bytes.size() - k * LANES;
      if (cnt > LANES) cnt = LANES;
      for (int j = 0; j < LANES; j++)
        bt.lanes[j] = (j < cnt) ? run_bytes[k * LANES + j] : 8'h00;
      bt.cnt = CNT_W'(cnt);
      bt.run_end = (k == nb - 1);
      bt.done = (k == nb - 1) && fin;
      bt.fault = (k == nb - 1) ? flt : FLT_OK;
      beat_q.push_back(bt);
    end
    return nb;
  endfunction

  task automatic send_req(req_s r);
    int gap;
    if (!no_idle && $urandom_range(0, 3) == 0) begin
      in_tvalid <= 1'b0;
      gap = $urandom_range(1, 7);
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= r.data;
    in_tuser <= r.start;
    in_tlast <= r.last;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    reqs_sent++;
    void'(predict_beats(r));
  endtask

  task automatic go_idle();
    in_tvalid <= 1'b0;
    while (beat_q.size() != 0) @(posedge clk);
    repeat (600) @(posedge clk);
  endtask

  task automatic write_len(logic [LEN_W-1:0] v);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= v;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    out_len = v;
  endtask

  // random stream, random content, some early references, sometimes broken at the end
  task automatic send_stream(int unsigned nbytes, logic broken);
    req_s r;
    int   cnt;
    int   k;
    int   nib;
    cnt = 0;
    for (int h = 0; h < HDR_BYTES; h++) begin
      r.start = (h == 0); r.data = 8'($urandom); r.last = 1'b0;
      send_req(r);
    end
    while (cnt < nbytes) begin
      r.start = 1'b0; r.last = 1'b0;
      r.data = (cnt < 4) ? 8'hFF : 8'($urandom);
      if (broken && $urandom_range(0, 5) == 0) r.data = 8'($urandom);
      send_req(r);
      k = r.data;
      for (int b = 7; b >= 0 && cnt < nbytes; b--) begin
        if (k[b]) begin
          r.data = 8'($urandom); send_req(r); cnt++;
        end else begin
          r.data = {4'($urandom_range(0, 15)), 4'(0)};
          if ($urandom_range(0, 7) == 0) r.data[3:0] = 4'($urandom);
          r.data[7:4] = $urandom_range(0, 3) == 0 ? 4'd0 : r.data[7:4];
          send_req(r);
          if (r.data[7:4] == 0) begin
            r.data = 8'($urandom_range(0, cnt < 1 ? 0 : cnt - 1)); send_req(r);
            r.data = $urandom_range(0, 4) == 0 ? 8'($urandom) : 8'($urandom_range(0, 10));
            send_req(r);
            cnt += r.data + 18;
          end else begin
            nib = r.data[7:4];
            r.data = 8'($urandom_range(0, cnt < 1 ? 0 : cnt - 1)); send_req(r);
            cnt += nib + 2;
          end
        end
      end
    end
    if (broken) begin
      r.start = 1'b0; r.data = 8'($urandom); r.last = 1'b1;
      send_req(r);
    end
  endtask

  // result checker
  always @(posedge clk) begin
    beat_s exp_b;
    if (rst_n && out_tvalid && out_tready) begin
      beats_seen++;
      if (beat_q.size() == 0) begin
        $error("unexpected beat: %h %h", out_tdata, out_tuser);
        errors++;
      end else begin
        exp_b = beat_q.pop_front();
        faults_seen[exp_b.fault]++;
        for (int j = 0; j < LANES; j++)
          if (out_tdata[j*8 +: 8] !== exp_b.lanes[j]) begin
            $error("lane_%0d expected %h actual %h", j, exp_b.lanes[j], out_tdata[j*8 +: 8]);
            errors++;
          end
        if (out_tdata[67:64] !== exp_b.cnt) begin
          $error("byte_count expected %0d actual %0d", exp_b.cnt, out_tdata[67:64]);
          errors++;
        end
        if (out_tlast !== exp_b.run_end) begin
          $error("run_end expected %b actual %b", exp_b.run_end, out_tlast);
          errors++;
        end
        if (out_tuser[0] !== exp_b.done) begin
          $error("stream_done expected %b actual %b", exp_b.done, out_tuser[0]);
          errors++;
        end
        if (out_tuser[2:1] !== exp_b.fault) begin
          $error("fault expected %0d actual %0d", exp_b.fault, out_tuser[2:1]);
          errors++;
        end
      end
    end
  end

  // receiver stalls in bursts; a long hold-off when requested
  initial begin
    int gap;
    out_tready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_out) begin
        out_tready <= 1'b0;
        repeat (400) @(posedge clk);
        hold_out = 1'b0;
      end else if (!no_idle && $urandom_range(0, 4) == 0) begin
        out_tready <= 1'b0;
        gap = $urandom_range(1, 7);
        repeat (gap - 1) @(posedge clk);
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  // watchdog on progress
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || !in_tvalid && beat_q.size() == 0)
      quiet <= 0;
    else begin
      quiet <= quiet + 1;
      if (quiet > STALL_LIMIT) begin
        $display("yaz0_stream_decoder_core test failed");
        $finish;
      end
    end
  end

  row_s dir_rows [$];
  req_s r;
  int   n_exp;

  initial begin
    errors = 0; beats_seen = 0; reqs_sent = 0; no_idle = 1'b0; hold_out = 1'b0;
    quiet = 0;
    for (int i = 0; i < 4; i++) faults_seen[i] = 0;
    rst_n = 1'b0; in_tvalid = 1'b0; in_tdata = '0; in_tuser = 1'b0; in_tlast = 1'b0;
    cfg_wr_en = 1'b0; cfg_wr_data = '0;
    out_len = '0;
    pred_reset();
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: output_length 0 after reset, no start flag on the first header byte
    for (int h = 0; h < HDR_BYTES; h++)
      dir_rows.push_back('{1'b0, 8'hA5, 1'b0, h == HDR_BYTES - 1, 1'b1, FLT_OK});
    dir_rows.push_back('{1'b0, 8'h00, 1'b0, 1'b0, 1'b0, FLT_OK}); // ignored after halt
    foreach (dir_rows[i]) begin
      r = '{dir_rows[i].start, dir_rows[i].data, dir_rows[i].last};
      n_exp = beat_q.size();
      send_req(r);
      if (dir_rows[i].has_exp && (beat_q.size() == n_exp ||
          beat_q[$].done !== dir_rows[i].exp_done || beat_q[$].fault !== dir_rows[i].exp_fault))
      begin
        $error("directed row %0d: predicted tail does not match table", i);
        errors++;
      end
    end
    go_idle();

    // literal, short ref, long ref, early reference, truncation, overrun
    write_len(27'd40);
    dir_rows.delete();
    for (int h = 0; h < HDR_BYTES; h++)
      dir_rows.push_back('{h == 0, 8'hFF, 1'b0, 1'b0, 1'b0, FLT_OK});
    foreach (dir_rows[i]) send_req('{dir_rows[i].start, dir_rows[i].data, 1'b0});
    send_req('{1'b0, 8'hA0, 1'b0});     // codes: lit, ref, lit, ref ...
    send_req('{1'b0, 8'h00, 1'b0});     // literal 0x00
    send_req('{1'b0, 8'hF0, 1'b0});     // short ref len 17
    send_req('{1'b0, 8'h00, 1'b0});
    send_req('{1'b0, 8'hFF, 1'b0});     // literal 0xFF
    send_req('{1'b0, 8'h00, 1'b0});     // long ref
    send_req('{1'b0, 8'h00, 1'b0});
    send_req('{1'b0, 8'hFF, 1'b0});     // len 273: overrun
    go_idle();
    write_len(27'd10);
    for (int h = 0; h < HDR_BYTES; h++) send_req('{h == 0, 8'h00, 1'b0});
    send_req('{1'b0, 8'h00, 1'b0});
    send_req('{1'b0, 8'h1F, 1'b0});     // distance beyond output: early reference
    send_req('{1'b0, 8'hFF, 1'b0});
    go_idle();
    for (int h = 0; h < HDR_BYTES; h++) send_req('{h == 0, 8'h00, 1'b0});
    send_req('{1'b0, 8'hFF, 1'b1});     // truncated
    go_idle();
    write_len(27'h7FFFFFF);
    for (int h = 0; h < HDR_BYTES; h++) send_req('{h == 0, 8'h5A, 1'b0});
    send_req('{1'b0, 8'hFF, 1'b0});
    send_req('{1'b0, 8'h81, 1'b1});
    go_idle();

    // random streams; one with a long receiver hold-off
    hold_out = 1'b1;
    while (reqs_sent < 390) begin
      write_len(27'($urandom_range(8, 120)));
      send_stream($urandom_range(8, 140), $urandom_range(0, 3) == 0);
      if (reqs_sent > 330) no_idle = 1'b1;
      go_idle();
    end

    $display("Sent %0d requests, checked %0d beats (faults: trunc %0d early %0d overrun %0d)",
             reqs_sent, beats_seen, faults_seen[FLT_TRUNC], faults_seen[FLT_EARLY],
             faults_seen[FLT_OVERRUN]);
    if (beat_q.size() != 0) begin
      $error("%0d expected beats never arrived", beat_q.size());
      errors++;
    end
    if (errors == 0) $display("yaz0_stream_decoder_core test passed");
    else $display("yaz0_stream_decoder_core test failed");
    $finish;
  end

endmodule
